>>> hdl/lpht_pkg.sv
package lpht_pkg;

  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;

  localparam logic [1:0] ACT_GET    = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_REPLACED = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [9:0] FILLED_LIMIT_RESET = 10'd768;

  typedef struct packed {
    logic        start;
    logic [63:0] key;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hash;
  } hash_rsp_t;

endpackage

>>> hdl/lpht_hash.sv
module lpht_hash import lpht_pkg::*; #(
  parameter int KEY_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  hash_req_t req,
  output hash_rsp_t rsp
);

  localparam int KEY_BYTES = (KEY_BITS + 7) / 8;
  localparam int CW = $clog2(KEY_BYTES + 1);

  logic [31:0] h;
  logic [63:0] sh;
  logic [CW-1:0] cnt;
  logic busy;
  logic [31:0] mixed;

  // one byte folded in per cycle through the shared multiplier
  assign mixed = h ^ {24'd0, sh[7:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
        h <= FNV_OFFSET;
        sh <= req.key;
      end else if (busy) begin
        h <= mixed * FNV_PRIME;
        sh <= {8'd0, sh[63:8]};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(KEY_BYTES - 1)) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

  assign rsp.hash = h;

endmodule

>>> hdl/linear_probe_hash_table.sv
// Open-addressing key/value table with linear probing and tombstones. Each
// item (get, insert or remove) hashes the key with 32-bit FNV-1a, one key
// byte per cycle through one shared multiplier, then walks the buckets in
// turn, a read state and then a check state for each, through the flag and
// key memory read ports; a get that hits then reads the value memory. A
// probe visits each bucket at most once, and a new item is accepted only
// after the result of the last one is taken. A get or remove on an empty
// table and the unused action skip the probe. in_stall is high while an item
// is in flight and while the result waits. After reset a clearing pass over
// all CAPACITY buckets zeroes the bucket flags, with in_stall high; key and
// value memories need no clearing. Inserts into never-used buckets are
// refused once claimed buckets reach filled_limit.
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int CAPACITY   = 1024,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] read_value,
  output logic [9:0]  bucket,
  output logic [9:0]  live_count
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CNTW = IW + 1;
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_VREAD = 3'd4;
  localparam logic [2:0] S_VDATA = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;
  localparam logic [2:0] S_CLEAR = 3'd7;

  // bucket flags as {occupied, tombstone}
  localparam logic [1:0] FLAG_FREE = 2'b00;
  localparam logic [1:0] FLAG_TOMB = 2'b01;
  localparam logic [1:0] FLAG_OCC  = 2'b10;

  logic [2:0] state;
  logic [9:0] filled_limit;
  logic [1:0]    flag_mem [CAPACITY];
  logic [KW-1:0] key_mem [CAPACITY];
  logic [VW-1:0] val_mem [CAPACITY];
  logic [1:0]    flag_rd;
  logic [KW-1:0] key_rd;
  logic [VW-1:0] val_rd;

  // item registers
  logic [1:0]    act;
  logic [KW-1:0] k;
  logic [VW-1:0] v;
  logic [IW-1:0] home, cur, tomb_at;
  logic          have_tomb;
  logic [CNTW-1:0] probed;
  logic [CNTW-1:0] entry_count, claimed_count;

  hash_req_t hreq;
  hash_rsp_t hrsp;

  lpht_hash #(.KEY_BITS(KW)) u_hash (
    .clk(clk), .rst(rst), .req(hreq), .rsp(hrsp)
  );

  assign hreq.start = (state == S_IDLE) && in_valid;
  assign hreq.key   = 64'(key[KW-1:0]);
  assign in_stall   = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = (state == S_OUT);
  assign live_count = 10'(entry_count);

  // memory write request from the decision step or the clearing pass
  logic          wr_key, wr_val, wr_flag;
  logic [1:0]    flag_wdata;
  logic [IW-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (wr_key) key_mem[wr_addr] <= k;
    if (wr_val) val_mem[wr_addr] <= v;
    if (wr_flag) flag_mem[wr_addr] <= flag_wdata;
    key_rd <= key_mem[cur];
    val_rd <= val_mem[cur];
    flag_rd <= flag_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled_limit <= FILLED_LIMIT_RESET;
    end else if (cfg_valid) begin
      filled_limit <= cfg_data;
    end
  end

  // probe result for the bucket under test
  logic is_occ, is_tomb, is_match, last_probe;
  logic [CNTW-1:0] limit_ext;
  assign is_occ     = flag_rd[1];
  assign is_tomb    = flag_rd[0];
  assign is_match   = is_occ && (key_rd == k);
  assign last_probe = (probed == CNTW'(CAPACITY - 1));
  assign limit_ext  = CNTW'(filled_limit);

  always_ff @(posedge clk) begin
    wr_key <= 1'b0;
    wr_val <= 1'b0;
    wr_flag <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      cur <= '0;
      entry_count <= '0;
      claimed_count <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          // one bucket flag cleared per cycle
          wr_flag <= 1'b1;
          flag_wdata <= FLAG_FREE;
          wr_addr <= cur;
          cur <= cur + IW'(1);
          if (cur == IW'(CAPACITY - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            act <= action;
            k <= key[KW-1:0];
            v <= value[VW-1:0];
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hrsp.done) begin
            home <= hrsp.hash[IW-1:0];
            cur <= hrsp.hash[IW-1:0];
            bucket <= 10'(hrsp.hash[IW-1:0]);
            have_tomb <= 1'b0;
            probed <= '0;
            status <= ST_NOTFOUND;
            read_value <= '0;
            // unused action, or a get or remove on an empty table: no probe
            if (act == ACT_UNUSED || (act != ACT_INSERT && entry_count == '0)) begin
              state <= S_OUT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (is_match) begin
            bucket <= 10'(cur);
            if (act == ACT_GET) begin
              status <= ST_DONE;
              state <= S_VREAD;
            end else if (act == ACT_REMOVE) begin
              status <= ST_DONE;
              wr_flag <= 1'b1; flag_wdata <= FLAG_TOMB; wr_addr <= cur;
              entry_count <= entry_count - CNTW'(1);
              state <= S_OUT;
            end else begin
              status <= ST_REPLACED;
              wr_val <= 1'b1;
              wr_addr <= cur;
              state <= S_OUT;
            end
          end else if (!is_occ && !is_tomb) begin
            // never-used bucket ends the probe
            state <= S_OUT;
            if (have_tomb) begin
              bucket <= 10'(tomb_at);
              if (act == ACT_INSERT) begin
                status <= ST_DONE;
                wr_flag <= 1'b1; flag_wdata <= FLAG_OCC;
                wr_key <= 1'b1; wr_val <= 1'b1; wr_addr <= tomb_at;
                entry_count <= entry_count + CNTW'(1);
              end
            end else begin
              bucket <= 10'(cur);
              if (act == ACT_INSERT) begin
                if (claimed_count < limit_ext) begin
                  status <= ST_DONE;
                  wr_flag <= 1'b1; flag_wdata <= FLAG_OCC;
                  wr_key <= 1'b1; wr_val <= 1'b1; wr_addr <= cur;
                  entry_count <= entry_count + CNTW'(1);
                  claimed_count <= claimed_count + CNTW'(1);
                end else begin
                  status <= ST_FULL;
                end
              end
            end
          end else begin
            logic have_t;
            logic [IW-1:0] t_at;
            have_t = have_tomb;
            t_at = tomb_at;
            if (!is_occ && is_tomb && !have_tomb) begin
              have_t = 1'b1;
              t_at = cur;
            end
            have_tomb <= have_t;
            tomb_at <= t_at;
            if (last_probe) begin
              // table exhausted
              state <= S_OUT;
              if (have_t) begin
                bucket <= 10'(t_at);
                if (act == ACT_INSERT) begin
                  status <= ST_DONE;
                  wr_flag <= 1'b1; flag_wdata <= FLAG_OCC;
                  wr_key <= 1'b1; wr_val <= 1'b1; wr_addr <= t_at;
                  entry_count <= entry_count + CNTW'(1);
                end
              end else begin
                bucket <= 10'(home);
                if (act == ACT_INSERT) status <= ST_FULL;
              end
            end else begin
              cur <= cur + IW'(1);
              probed <= probed + CNTW'(1);
              state <= S_READ;
            end
          end
        end
        S_VREAD: begin
          state <= S_VDATA;
        end
        S_VDATA: begin
          read_value <= 32'(val_rd);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
